/* design/swmv_pkg.sv */
// shared constants and width helpers for the sliding window mean and variance block
`timescale 1ns / 1ps
`default_nettype none

package swmv_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAX_WINDOW  = 64;
   localparam int DEF_SAMPLE_BITS = 16;

   // window length register
   localparam int CFG_W          = 7;
   localparam int MIN_WINDOW     = 2;
   localparam int RESET_WINDOW   = 8;

   // result and queue sizing
   localparam int VAR_W          = 31;
   localparam int QUEUE_DEPTH    = 2;

   // signed running sum of up to max_window samples
   function automatic int sum_width(input int max_window, input int sample_bits);
      return sample_bits + $clog2(max_window) + 1;
   endfunction

   // unsigned running sum of squares
   function automatic int sq_width(input int max_window, input int sample_bits);
      return 2 * sample_bits + $clog2(max_window);
   endfunction

   // bit count rounded up to whole bytes
   function automatic int byte_width(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction

endpackage

`default_nettype wire

/* design/swmv_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module swmv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/swmv_queue.sv */
// small fifo between the window front end and the divider back end
`timescale 1ns / 1ps
`default_nettype none

module swmv_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= CW'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= CW'(count_ff - 1'b1);
         end
      end
   end

endmodule

`default_nettype wire

/* design/swmv_front.sv */
// window front end: takes samples, keeps the ring and the running sums
`timescale 1ns / 1ps
`default_nettype none

module swmv_front import swmv_pkg::*; #(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wen,
   input  wire logic [CFG_W-1:0]       csr_wdata,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic                   in_start,
   output logic                        job_valid,
   input  wire logic                   job_ready,
   output logic [CFG_W + sq_width(MAX_WINDOW, SAMPLE_BITS)
                 + sum_width(MAX_WINDOW, SAMPLE_BITS) - 1:0] job_data
);

   localparam int SUM_W = sum_width(MAX_WINDOW, SAMPLE_BITS);
   localparam int SQ_W  = sq_width(MAX_WINDOW, SAMPLE_BITS);
   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int PR_W  = 2 * SAMPLE_BITS;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SQUARE,
      F_UPDATE
   } front_state_type;

   front_state_type           state_ff;
   logic [CFG_W-1:0]          p_ff;
   logic [PTR_W-1:0]          ptr_ff;
   logic [CFG_W-1:0]          fill_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] old_ff;
   logic                      full_ff;
   logic [PR_W-1:0]           old_sq_ff;
   logic [PR_W-1:0]           new_sq_ff;

   logic [CFG_W-1:0]          p_in;
   logic                      accept;
   logic [PTR_W-1:0]          base_ptr;
   logic [PTR_W-1:0]          rd_addr;
   logic [PTR_W:0]            ptr_inc;
   logic [PTR_W-1:0]          ptr_in;
   logic [CFG_W-1:0]          fill_in;
   logic                      emit;
   logic                      advance;
   logic signed [SUM_W-1:0]   sum_in;
   logic [SQ_W-1:0]           sq_in;
   logic [SAMPLE_BITS-1:0]    ram_rdata;
   logic signed [PR_W-1:0]    old_ext;
   logic signed [PR_W-1:0]    new_ext;

   // clamp of the written window length
   always_comb begin
      if (csr_wdata < CFG_W'(MIN_WINDOW)) begin
         p_in = CFG_W'(MIN_WINDOW);
      end else if (32'(csr_wdata) > MAX_WINDOW) begin
         p_in = CFG_W'(MAX_WINDOW);
      end else begin
         p_in = csr_wdata;
      end
   end

   assign in_ready = (state_ff == F_IDLE);
   assign accept   = in_valid && in_ready;

   // slot for this sample, after a start clear and the wrap at p
   assign base_ptr = in_start ? '0 : ptr_ff;
   assign rd_addr  = (32'(base_ptr) >= 32'(p_ff)) ? '0 : base_ptr;

   assign ptr_inc  = {1'b0, ptr_ff} + 1'b1;
   assign ptr_in   = (32'(ptr_inc) >= 32'(p_ff)) ? '0 : ptr_inc[PTR_W-1:0];
   assign fill_in  = full_ff ? fill_ff : CFG_W'(fill_ff + 1'b1);
   assign emit     = (fill_in >= p_ff);
   assign advance  = (state_ff == F_UPDATE) && (!emit || job_ready);

   assign sum_in = sum_ff - (full_ff ? SUM_W'(old_ff) : '0) + SUM_W'(sample_ff);
   assign sq_in  = sq_ff - (full_ff ? SQ_W'(old_sq_ff) : '0) + SQ_W'(new_sq_ff);

   assign old_ext = PR_W'($signed(ram_rdata));
   assign new_ext = PR_W'(sample_ff);

   assign job_valid = (state_ff == F_UPDATE) && emit;
   assign job_data  = {p_ff, sq_in, sum_in};

   swmv_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (ptr_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         p_ff     <= CFG_W'(RESET_WINDOW);
         ptr_ff   <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         full_ff  <= 1'b0;
      end else if (csr_wen) begin
         p_ff    <= p_in;
         ptr_ff  <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  sample_ff <= in_sample;
                  ptr_ff    <= rd_addr;
                  if (in_start) begin
                     fill_ff <= '0;
                     sum_ff  <= '0;
                     sq_ff   <= '0;
                     full_ff <= 1'b0;
                  end else begin
                     full_ff <= (fill_ff >= p_ff);
                  end
                  state_ff <= F_SQUARE;
               end
            end
            F_SQUARE: begin
               old_ff    <= $signed(ram_rdata);
               old_sq_ff <= PR_W'(old_ext * old_ext);
               new_sq_ff <= PR_W'(new_ext * new_ext);
               state_ff  <= F_UPDATE;
            end
            F_UPDATE: begin
               if (advance) begin
                  sum_ff   <= sum_in;
                  sq_ff    <= sq_in;
                  ptr_ff   <= ptr_in;
                  fill_ff  <= fill_in;
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/swmv_back.sv */
// back end: bit serial square and dividers, output register
`timescale 1ns / 1ps
`default_nettype none

module swmv_back import swmv_pkg::*; #(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  job_valid,
   output logic       job_ready,
   input  wire logic [CFG_W + sq_width(MAX_WINDOW, SAMPLE_BITS)
                      + sum_width(MAX_WINDOW, SAMPLE_BITS) - 1:0] job_data,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   output logic [byte_width(SAMPLE_BITS + VAR_W)-1:0] rsp_tdata
);

   localparam int SUM_W  = sum_width(MAX_WINDOW, SAMPLE_BITS);
   localparam int SQ_W   = sq_width(MAX_WINDOW, SAMPLE_BITS);
   localparam int SSQ_W  = 2 * SUM_W;
   localparam int NUM_W  = SQ_W + CFG_W;
   localparam int NW     = (NUM_W > SSQ_W) ? NUM_W : SSQ_W;
   localparam int DEN_W  = 2 * CFG_W;
   localparam int STEPS  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
   localparam int CNT_W  = $clog2(STEPS);
   localparam int RSP_W  = byte_width(SAMPLE_BITS + VAR_W);

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_NUM,
      B_DIV,
      B_DONE
   } back_state_type;

   back_state_type          state_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    neg_ff;
   logic [CFG_W-1:0]        p_ff;
   logic [NUM_W-1:0]        psq_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [SSQ_W-1:0]        sqa_ff;
   logic [SUM_W-1:0]        sqb_ff;
   logic [SSQ_W-1:0]        acc_ff;
   logic [CFG_W:0]          mrem_ff;
   logic [SUM_W-1:0]        mq_ff;
   logic [SAMPLE_BITS-1:0]  mean_ff;
   logic [DEN_W:0]          vrem_ff;
   logic [NUM_W-1:0]        vq_ff;
   logic                    rsp_valid_ff;
   logic [RSP_W-1:0]        rsp_data_ff;

   logic signed [SUM_W-1:0] job_sum;
   logic [SQ_W-1:0]         job_sq;
   logic [CFG_W-1:0]        job_p;
   logic [SUM_W-1:0]        job_mag;
   logic [CFG_W:0]          mrem_try;
   logic                    mge;
   logic [DEN_W:0]          vrem_try;
   logic                    vge;
   logic [NW-1:0]           diff;
   logic [SUM_W-1:0]        mean_full;
   logic                    load_out;

   assign job_sum = $signed(job_data[SUM_W-1:0]);
   assign job_sq  = job_data[SUM_W +: SQ_W];
   assign job_p   = job_data[SUM_W + SQ_W +: CFG_W];
   assign job_mag = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);

   assign job_ready = (state_ff == B_IDLE);

   // restoring division steps, one quotient bit per cycle
   assign mrem_try = {mrem_ff[CFG_W-1:0], mq_ff[SUM_W-1]};
   assign mge      = (mrem_try >= {1'b0, p_ff});
   assign vrem_try = {vrem_ff[DEN_W-1:0], vq_ff[NUM_W-1]};
   assign vge      = (vrem_try >= {1'b0, den_ff});

   assign diff      = NW'(psq_ff) - NW'(acc_ff);
   assign mean_full = neg_ff ? SUM_W'(-mq_ff) : mq_ff;
   assign load_out  = (state_ff == B_DONE) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= RSP_W'({VAR_W'(vq_ff), mean_ff});
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            B_IDLE: begin
               if (job_valid) begin
                  neg_ff   <= job_sum[SUM_W-1];
                  p_ff     <= job_p;
                  psq_ff   <= NUM_W'(NUM_W'(job_p) * NUM_W'(job_sq));
                  den_ff   <= DEN_W'(DEN_W'(job_p) * DEN_W'(job_p - 1'b1));
                  sqa_ff   <= SSQ_W'(job_mag);
                  sqb_ff   <= job_mag;
                  acc_ff   <= '0;
                  mrem_ff  <= '0;
                  mq_ff    <= job_mag;
                  cnt_ff   <= '0;
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               // square by shift and add, mean quotient alongside
               if (sqb_ff[0]) begin
                  acc_ff <= acc_ff + sqa_ff;
               end
               sqa_ff  <= {sqa_ff[SSQ_W-2:0], 1'b0};
               sqb_ff  <= {1'b0, sqb_ff[SUM_W-1:1]};
               mrem_ff <= mge ? (mrem_try - {1'b0, p_ff}) : mrem_try;
               mq_ff   <= {mq_ff[SUM_W-2:0], mge};
               if (cnt_ff == CNT_W'(SUM_W - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= B_NUM;
               end else begin
                  cnt_ff <= CNT_W'(cnt_ff + 1'b1);
               end
            end
            B_NUM: begin
               mean_ff  <= mean_full[SAMPLE_BITS-1:0];
               vq_ff    <= diff[NUM_W-1:0];
               vrem_ff  <= '0;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               vrem_ff <= vge ? (vrem_try - {1'b0, den_ff}) : vrem_try;
               vq_ff   <= {vq_ff[NUM_W-2:0], vge};
               if (cnt_ff == CNT_W'(NUM_W - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= B_DONE;
               end else begin
                  cnt_ff <= CNT_W'(cnt_ff + 1'b1);
               end
            end
            B_DONE: begin
               if (load_out) begin
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/sliding_window_mean_variance.sv */
// top level of the sliding window mean and sample variance block
`timescale 1ns / 1ps
`default_nettype none

// Sliding window mean and sample variance. Each input word carries one signed
// sample (tdata) and a start flag (tuser) that clears the window before the
// sample is taken. The block keeps the last P samples in a ring memory with a
// running sum and sum of squares; once P samples have arrived since the last
// clear, every sample yields one result word: mean = sum / P and variance =
// (P*sumsq - sum^2) / (P*(P-1)), both truncated toward zero. P is written on
// the csr port (2..MAX_WINDOW, clamped) and a write also clears the window;
// write it only while the block is idle. Reset sets P to 8. The front end
// takes one sample at a time through ring read, squaring and a sum update
// that waits on a full queue. The back end squares and divides bit serially
// to SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) + 1 and NUM_W = 2*SAMPLE_BITS +
// clog2(MAX_WINDOW) + 7 quotient bits and takes no new job until its result
// is loaded. A two entry queue and the output register let the front end
// keep accepting while results wait; no clearing pass is needed after reset.

module sliding_window_mean_variance import swmv_pkg::*; #(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // window length register
   input  wire logic                   csr_wen,
   input  wire logic [CFG_W-1:0]       csr_wdata,
   // sample words
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [byte_width(SAMPLE_BITS)-1:0] req_tdata,  // sample
   input  wire logic                   req_tuser,                 // start_req
   // result words
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [byte_width(SAMPLE_BITS + VAR_W)-1:0] rsp_tdata // mean, variance
);

   localparam int JOB_W = CFG_W + sq_width(MAX_WINDOW, SAMPLE_BITS)
                          + sum_width(MAX_WINDOW, SAMPLE_BITS);

   // front end to queue
   logic             fj_valid;
   logic             fj_ready;
   logic [JOB_W-1:0] fj_data;
   // queue to back end
   logic             bj_valid;
   logic             bj_ready;
   logic [JOB_W-1:0] bj_data;

   swmv_front #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .in_start  (req_tuser),
      .job_valid (fj_valid),
      .job_ready (fj_ready),
      .job_data  (fj_data)
   );

   // window snapshots waiting for the dividers
   swmv_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_ready (fj_ready),
      .push_data  (fj_data),
      .pop_valid  (bj_valid),
      .pop_ready  (bj_ready),
      .pop_data   (bj_data)
   );

   swmv_back #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (bj_valid),
      .job_ready  (bj_ready),
      .job_data   (bj_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
